/* src/smpq_pkg.sv */
// Shared types and constants for the sorted minimum-first priority queue.
// No dependencies.
package smpq_pkg;

    localparam int VALUE_W = 32;
    localparam int HELD_COUNT_W = 5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

/* src/sorted_min_priority_queue_core.sv */
// Top level of the sorted minimum-first priority queue: a row of smpq_cell.
// Depends on smpq_pkg and smpq_cell.
//
// Usage:
//   Raise start with command and value for one cycle; the word is taken at
//   that edge when busy is low. busy stays low, so a word can be taken in
//   every cycle.
//   A push (command 0) inserts value at its sorted place, every
//   cell comparing against the new word at once and shifting in parallel.
//   A pop (command 1) shifts the whole row one cell towards the head; a pop
//   of an empty queue changes nothing. A push to a full queue is dropped.
//   In the cycle after each taken word, done is high for exactly one cycle with
//   top_value (smallest held value, 0 when empty), is_empty, is_full,
//   held_count (low five bits of the count) and dropped. The receiver cannot
//   stall; the result must be taken while shown.
//   Reset clears the count and the strobe; the queue starts empty.
module sorted_min_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   command,
    input  smpq_pkg::value_t                       value,
    output logic                                   done,
    output smpq_pkg::value_t                       top_value,
    output logic                                   is_empty,
    output logic                                   is_full,
    output logic [smpq_pkg::HELD_COUNT_W-1:0]      held_count,
    output logic                                   dropped
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             dropped_reg;
    logic             dropped_next;
    logic             accept;
    logic             full_now;
    cell_ctrl_t       ctrl;

    logic   [CAPACITY-1:0] lt;
    value_t                cell_values [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign full_now = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl.push    = 1'b0;
        ctrl.pop     = 1'b0;
        count_next   = count_reg;
        dropped_next = 1'b0;
        if (accept)
        begin
            case (command)
                CMD_PUSH:
                begin
                    if (full_now)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (count_reg != '0)
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_lt_w;
        value_t left_value_w;
        value_t right_value_w;

        if (i == 0)
        begin : g_head
            assign left_lt_w    = 1'b0;
            assign left_value_w = value;
        end
        else
        begin : g_body
            assign left_lt_w    = lt[i-1];
            assign left_value_w = cell_values[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value_w = '0;
        end
        else
        begin : g_inner
            assign right_value_w = cell_values[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .in_value    (value),
            .occupied    (count_reg > CNT_W'(i)),
            .left_lt     (left_lt_w),
            .left_value  (left_value_w),
            .right_value (right_value_w),
            .lt          (lt[i]),
            .cell_value  (cell_values[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            done_reg    <= accept;
            dropped_reg <= dropped_next;
        end
    end

    assign done       = done_reg;
    assign is_empty   = (count_reg == '0);
    assign is_full    = full_now;
    assign top_value  = is_empty ? '0 : cell_values[0];
    assign held_count = HELD_COUNT_W'(count_reg);
    assign dropped    = dropped_reg;

endmodule

/* src/smpq_cell.sv */
// One storage cell of the sorted row: holds one value and hands it on.
// Depends on smpq_pkg.
module smpq_cell (
    input  logic                clk,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  smpq_pkg::value_t    in_value,
    input  logic                occupied,
    input  logic                left_lt,
    input  smpq_pkg::value_t    left_value,
    input  smpq_pkg::value_t    right_value,
    output logic                lt,
    output smpq_pkg::value_t    cell_value
);
    import smpq_pkg::*;

    value_t value_reg;
    value_t value_next;

    // New word sorts before this cell when the cell is empty or holds a larger value.
    assign lt = !occupied || (in_value < value_reg);
    assign cell_value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.pop)
        begin
            value_next = right_value;
        end
        else if (ctrl.push)
        begin
            if (left_lt)
            begin
                value_next = left_value;
            end
            else if (lt)
            begin
                value_next = in_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* sim/smpq_checker.sv */
// Checker for the sorted minimum-first priority queue: watches the word and result
// channels, predicts each result from its own sorted copy of the queue and compares.
// Depends on smpq_pkg.
`timescale 1ns / 100ps

module smpq_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               command,
    input  smpq_pkg::value_t                   value,
    input  logic                               done,
    input  smpq_pkg::value_t                   top_value,
    input  logic                               is_empty,
    input  logic                               is_full,
    input  logic [smpq_pkg::HELD_COUNT_W-1:0]  held_count,
    input  logic                               dropped,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 drop_count,
    output int                                 empty_pop_count
);
    import smpq_pkg::*;

    typedef struct packed {
        value_t                  top;
        logic                    empty;
        logic                    full;
        logic [HELD_COUNT_W-1:0] count;
        logic                    drop;
    } queue_report_t;

    // ascending order: the smallest value sits at index 0
    value_t        held [CAPACITY];
    int unsigned   held_n;
    queue_report_t report_q [$];

    function automatic queue_report_t apply_word(input logic cmd, input value_t v);
        queue_report_t r;
        int i;
        r.drop = 1'b0;
        if (cmd == CMD_PUSH) begin
            if (held_n >= CAPACITY) begin
                r.drop = 1'b1;
                drop_count++;
            end
            else begin
                i = held_n;
                while (i > 0 && held[i-1] > v) begin
                    held[i] = held[i-1];
                    i--;
                end
                held[i] = v;
                held_n++;
            end
        end
        else if (held_n > 0) begin
            for (i = 0; i + 1 < held_n; i++)
                held[i] = held[i+1];
            held_n--;
        end
        else begin
            empty_pop_count++;
        end
        r.top   = (held_n > 0) ? held[0] : '0;
        r.empty = (held_n == 0);
        r.full  = (held_n >= CAPACITY);
        r.count = held_n[HELD_COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        queue_report_t want;
        if (!rst_n) begin
            held_n = 0;
            report_q.delete();
            fail_count = 0;
            pending = 0;
            drop_count = 0;
            empty_pop_count = 0;
        end
        else begin
            if (done) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result with no word outstanding, got top_value %0h",
                             $time, top_value);
                    fail_count++;
                end
                else begin
                    want = report_q.pop_front();
                    check_field("top_value", want.top, top_value);
                    check_field("is_empty", want.empty, is_empty);
                    check_field("is_full", want.full, is_full);
                    check_field("held_count", want.count, held_count);
                    check_field("dropped", want.drop, dropped);
                end
            end
            if (start && !busy)
                report_q.push_back(apply_word(command, value));
            pending = report_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the testbench for the sorted minimum-first priority queue: clock, reset,
// directed and random words under several pacing phases, watchdog and verdict.
// Depends on smpq_pkg, sorted_min_priority_queue_core and smpq_checker.
`timescale 1ns / 100ps

module testbench;
    import smpq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int IDLE_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    command;
    value_t                  value;
    logic                    done;
    value_t                  top_value;
    logic                    is_empty;
    logic                    is_full;
    logic [HELD_COUNT_W-1:0] held_count;
    logic                    dropped;

    int fail_count;
    int pending;
    int drop_count;
    int empty_pop_count;
    int push_sent;
    int pop_sent;
    int idle_cycles;

    sorted_min_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .done(done),
        .top_value(top_value),
        .is_empty(is_empty),
        .is_full(is_full),
        .held_count(held_count),
        .dropped(dropped)
    );

    smpq_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .done(done),
        .top_value(top_value),
        .is_empty(is_empty),
        .is_full(is_full),
        .held_count(held_count),
        .dropped(dropped),
        .fail_count(fail_count),
        .pending(pending),
        .drop_count(drop_count),
        .empty_pop_count(empty_pop_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic value_t pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4, 5: return value_t'($urandom_range(8)) - 4;
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic cmd, input value_t v);
        start   <= 1'b1;
        command <= cmd;
        value   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_PUSH)
            push_sent++;
        else
            pop_sent++;
    endtask

    // drop start for a random number of cycles, about pct in a hundred
    task automatic hold_off(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < pct)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_pct [4];
        int pct;
        int push_pct;
        logic cmd;
        phase_pct = '{0, 64, 0, 33};
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_PUSH;
        value = '0;
        push_sent = 0;
        pop_sent = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes and duplicates, fill, overflow, a few pops
        send_word(CMD_POP, '1);
        send_word(CMD_PUSH, 32'h7fff_ffff);
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, '0);
        send_word(CMD_PUSH, '1);
        send_word(CMD_PUSH, '0);
        repeat (CAPACITY - 5)
            send_word(CMD_PUSH, pick_value());
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'h7fff_ffff);
        repeat (3)
            send_word(CMD_POP, pick_value());

        // random: four pacing phases, push bias changing every forty words
        for (int phase = 0; phase < 4; phase++) begin
            for (int seg = 0; seg < 13; seg++) begin
                case ($urandom_range(3))
                    0: push_pct = 15;
                    1: push_pct = 45;
                    2: push_pct = 80;
                    default: push_pct = 95;
                endcase
                pct = ($urandom_range(3) == 0) ? 0 : phase_pct[phase];
                repeat (40) begin
                    cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                    send_word(cmd, pick_value());
                    hold_off(pct);
                end
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("tb: %0d words sent, %0d pushes and %0d pops, over four pacing phases",
                 push_sent + pop_sent, push_sent, pop_sent);
        $display("tb: %0d pushes dropped on a full queue, %0d pops on an empty queue",
                 drop_count, empty_pop_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sorted_min_priority_queue_core.f */
src/smpq_pkg.sv
src/smpq_cell.sv
src/sorted_min_priority_queue_core.sv
sim/smpq_checker.sv
sim/testbench.sv
